// ===== design/fdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types and constants for the floppy disk controller port unit.
// ----------------------------------------------------------------------------
package fdc_pkg;

	localparam int FDC_DRIVES        = 4;
	localparam int FDC_TRACKS        = 8;
	localparam int SECTORS_PER_TRACK = 32;
	localparam int SECTOR_BYTES      = 137;

	localparam int OP_W   = 3;
	localparam int DATA_W = 8;
	localparam int TRK_W  = 7;
	localparam int SECT_W = 6;
	localparam int TGT_W  = 13;

	// Port operation codes; the two remaining codes do nothing
	typedef enum logic [OP_W-1:0] {
		OP_SELECT  = 3'd0,
		OP_CONTROL = 3'd1,
		OP_STATUS  = 3'd2,
		OP_SECTOR  = 3'd3,
		OP_WRITE   = 3'd4,
		OP_READ    = 3'd5
	} op_t;

	// Active-low status bits
	localparam logic [7:0] ST_ENWD = 8'h01;
	localparam logic [7:0] ST_HEAD = 8'h04;
	localparam logic [7:0] ST_TRK0 = 8'h40;
	localparam logic [7:0] ST_NRDA = 8'h80;

	// Control port bit positions
	localparam int CT_STEP_IN     = 0;
	localparam int CT_STEP_OUT    = 1;
	localparam int CT_HEAD_LOAD   = 2;
	localparam int CT_HEAD_UNLOAD = 3;
	localparam int CT_WE          = 7;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic accept;
		logic apply;
		logic flush;
		logic fill;
		logic read;
		logic result;
		logic clear;
	} fdc_cmd_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic pre_flush;
		logic post_flush;
		logic need_fill;
		logic is_wr;
		logic is_rd;
		logic copy_done;
		logic clear_done;
	} fdc_sts_t;

endpackage

// ===== design/fdc_req_if.sv =====
// ----------------------------------------------------------------------------
// fdc_req_if
// Port access channel: operation code and written byte.
// ----------------------------------------------------------------------------
interface fdc_req_if import fdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [DATA_W-1:0] data;

	modport source (output valid, output op, output data, input ready);
	modport sink (input valid, input op, input data, output ready);
endinterface

// ===== design/fdc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fdc_rsp_if
// Result channel: byte returned by each port access.
// ----------------------------------------------------------------------------
interface fdc_rsp_if import fdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

// ===== design/fdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdc_ctrl
// Sequencer: steps each item through check, flush, update, fill and read.
// ----------------------------------------------------------------------------
module fdc_ctrl import fdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  fdc_sts_t  sts,
	output fdc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_FLUSH, S_APPLY, S_FILL, S_READ, S_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	// Take a new item only when idle and the result slot is free or draining
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Decode commands from state
	always_comb begin
		cmd.accept = accept;
		cmd.apply  = (state_q == S_APPLY);
		cmd.flush  = (state_q == S_FLUSH);
		cmd.fill   = (state_q == S_FILL);
		cmd.read   = (state_q == S_READ);
		cmd.result = (state_q == S_RESULT);
		cmd.clear  = (state_q == S_CLEAR);
	end

	// Hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clear_done) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= sts.pre_flush ? S_FLUSH : S_APPLY;
				end
				S_APPLY: begin
					if (sts.is_wr && sts.post_flush) state_q <= S_FLUSH;
					else if (sts.is_rd) state_q <= sts.need_fill ? S_FILL : S_READ;
					else state_q <= S_RESULT;
				end
				S_FLUSH: begin
					if (sts.copy_done) state_q <= sts.is_wr ? S_RESULT : S_APPLY;
				end
				S_FILL: begin
					if (sts.copy_done) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_rise_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESULT))
		else $error("result valid rose outside the result step");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESULT |-> !out_valid_q)
		else $error("result slot still occupied when a result is due");

	a_flush_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && sts.copy_done) |=>
		(state_q == S_APPLY || state_q == S_RESULT))
		else $error("flush finished into a wrong step");

endmodule

// ===== design/fdc_dp.sv =====
// ----------------------------------------------------------------------------
// fdc_dp
// Datapath: per-drive registers, sector buffers, disk-image memory and the
// byte copy engine between them.
// ----------------------------------------------------------------------------
module fdc_dp import fdc_pkg::*; #(
	parameter int DRIVES = FDC_DRIVES,
	parameter int TRACKS = FDC_TRACKS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [OP_W-1:0]   in_op,
	input  logic [DATA_W-1:0] in_data,
	input  fdc_cmd_t          cmd,
	output fdc_sts_t          sts,
	output logic [DATA_W-1:0] rd_data_q
);

	localparam int DW          = (DRIVES > 1) ? $clog2(DRIVES) : 1;
	localparam int BUF_DEPTH   = DRIVES * SECTOR_BYTES;
	localparam int BUF_AW      = $clog2(BUF_DEPTH);
	localparam int DRIVE_BYTES = TRACKS * SECTORS_PER_TRACK * SECTOR_BYTES;
	localparam int IMG_DEPTH   = DRIVES * DRIVE_BYTES;
	localparam int IMG_AW      = $clog2(IMG_DEPTH);

	op_t               op_q;
	logic [DATA_W-1:0] data_q;
	logic [1:0]        cur_q;
	logic [DW-1:0]     drv;

	logic [TRK_W-1:0]  track_q [DRIVES];
	logic [SECT_W-1:0] sect_q  [DRIVES];
	logic [7:0]        stat_q  [DRIVES];
	logic [7:0]        cnt_q   [DRIVES];
	logic [7:0]        idx_q   [DRIVES];
	logic [TGT_W-1:0]  tgt_q   [DRIVES];
	logic              valid_q [DRIVES];
	logic              dirty_q [DRIVES];

	logic [7:0]        cp_q;
	logic [IMG_AW-1:0] clr_q;
	logic [7:0]        res_q;
	logic              ok_q;

	logic [7:0]        buf_mem [BUF_DEPTH];
	logic [7:0]        img_mem [IMG_DEPTH];
	logic [7:0]        buf_rd_q;
	logic [7:0]        img_rd_q;

	logic              fill_we_s1;
	logic [BUF_AW-1:0] fill_addr_s1;
	logic              flush_we_s1;
	logic [IMG_AW-1:0] flush_addr_s1;

	logic [BUF_AW-1:0] buf_base, buf_cp_addr, buf_idx_addr, buf_raddr, buf_waddr;
	logic [IMG_AW-1:0] img_base, img_cp_addr, img_waddr;
	logic [7:0]        buf_wdata, img_wdata;
	logic              buf_we, img_we;

	logic              idx_ok;
	logic [7:0]        cnt_next;
	logic              step_in, step_out, stepping;
	logic [TRK_W-1:0]  trk_in, trk_out;
	logic [7:0]        stat_ctl;
	logic [SECT_W-1:0] sect_cur;
	logic [3:0]        sel;

	assign drv = cur_q[DW-1:0];
	assign sel = data_q[3:0];

	// Form buffer and image addresses for the selected drive
	assign buf_base     = BUF_AW'(int'(drv) * SECTOR_BYTES);
	assign buf_cp_addr  = buf_base + BUF_AW'(cp_q);
	assign buf_idx_addr = buf_base + BUF_AW'(idx_q[drv]);
	assign img_base     = IMG_AW'(drv) * IMG_AW'(DRIVE_BYTES)
		+ IMG_AW'(tgt_q[drv]) * IMG_AW'(SECTOR_BYTES);
	assign img_cp_addr  = img_base + IMG_AW'(cp_q);

	assign idx_ok   = idx_q[drv] < 8'(SECTOR_BYTES);
	assign cnt_next = (cnt_q[drv] < 8'(SECTOR_BYTES)) ? cnt_q[drv] + 8'd1 : cnt_q[drv];

	// Work out head stepping and the new status byte for a control write
	always_comb begin
		step_in  = data_q[CT_STEP_IN];
		step_out = data_q[CT_STEP_OUT];
		stepping = step_in || step_out;
		trk_in   = (step_in && track_q[drv] < TRK_W'(TRACKS - 1))
			? track_q[drv] + TRK_W'(1) : track_q[drv];
		trk_out  = (step_out && trk_in != '0) ? trk_in - TRK_W'(1) : trk_in;
		stat_ctl = stat_q[drv];
		if (step_in && trk_in != '0) stat_ctl = stat_ctl | ST_TRK0;
		if (step_out && trk_out == '0) stat_ctl = stat_ctl & ~ST_TRK0;
		if (data_q[CT_HEAD_LOAD]) stat_ctl = stat_ctl & ~(ST_HEAD | ST_NRDA);
		if (data_q[CT_HEAD_UNLOAD]) stat_ctl = stat_ctl | ST_HEAD;
		if (data_q[CT_WE]) stat_ctl = stat_ctl & ~ST_ENWD;
		sect_cur = (sect_q[drv] >= SECT_W'(SECTORS_PER_TRACK)) ? '0 : sect_q[drv];
	end

	// Report conditions to the sequencer
	always_comb begin
		sts.pre_flush  = dirty_q[drv] &&
			((op_q == OP_CONTROL && stepping) || op_q == OP_SECTOR);
		sts.post_flush = cnt_next >= 8'(SECTOR_BYTES);
		sts.need_fill  = !valid_q[drv];
		sts.is_wr      = (op_q == OP_WRITE);
		sts.is_rd      = (op_q == OP_READ);
		sts.copy_done  = cp_q == 8'(SECTOR_BYTES);
		sts.clear_done = clr_q == IMG_AW'(IMG_DEPTH - 1);
	end

	// Steer memory ports
	assign buf_raddr = cmd.flush ? buf_cp_addr : buf_idx_addr;
	assign buf_we    = fill_we_s1 || (cmd.apply && op_q == OP_WRITE && idx_ok);
	assign buf_waddr = fill_we_s1 ? fill_addr_s1 : buf_idx_addr;
	assign buf_wdata = fill_we_s1 ? img_rd_q : data_q;
	assign img_we    = cmd.clear || flush_we_s1;
	assign img_waddr = cmd.clear ? clr_q : flush_addr_s1;
	assign img_wdata = cmd.clear ? 8'd0 : buf_rd_q;

	// Sector buffer memory
	always_ff @(posedge clk) begin
		if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
		buf_rd_q <= buf_mem[buf_raddr];
	end

	// Disk image memory
	always_ff @(posedge clk) begin
		if (img_we) img_mem[img_waddr] <= img_wdata;
		img_rd_q <= img_mem[img_cp_addr];
	end

	// Capture the item, the copy pipeline addresses and the result byte
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op_t'(in_op);
			data_q <= in_data;
		end
		fill_addr_s1  <= buf_cp_addr;
		flush_addr_s1 <= img_cp_addr;
		if (cmd.apply) begin
			unique case (op_q)
				OP_STATUS: res_q <= stat_q[drv];
				OP_SECTOR: res_q <= {1'b0, sect_cur, 1'b0};
				default:   res_q <= 8'd0;
			endcase
		end
		if (cmd.result) begin
			rd_data_q <= (op_q == OP_READ) ? (ok_q ? buf_rd_q : 8'd0) : res_q;
		end
	end

	// Advance copy and clearing counters, and the per-drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			cp_q        <= '0;
			clr_q       <= '0;
			ok_q        <= 1'b0;
			fill_we_s1  <= 1'b0;
			flush_we_s1 <= 1'b0;
			for (int i = 0; i < DRIVES; i++) begin
				track_q[i] <= '0;
				sect_q[i]  <= '0;
				stat_q[i]  <= 8'hFF;
				cnt_q[i]   <= '0;
				idx_q[i]   <= '0;
				tgt_q[i]   <= '0;
				valid_q[i] <= 1'b0;
				dirty_q[i] <= 1'b0;
			end
		end else begin
			fill_we_s1  <= cmd.fill && cp_q < 8'(SECTOR_BYTES);
			flush_we_s1 <= cmd.flush && cp_q < 8'(SECTOR_BYTES);
			cp_q        <= ((cmd.flush || cmd.fill) && !sts.copy_done) ? cp_q + 8'd1 : 8'd0;
			if (cmd.clear) clr_q <= clr_q + IMG_AW'(1);

			if (cmd.apply) begin
				unique case (op_q)
					OP_SELECT: begin
						cur_q <= (int'(sel) < DRIVES) ? sel[1:0] : 2'd0;
					end
					OP_CONTROL: begin
						track_q[drv] <= trk_out;
						stat_q[drv]  <= stat_ctl;
						if (data_q[CT_WE]) cnt_q[drv] <= '0;
						if (stepping) begin
							sect_q[drv]  <= '0;
							tgt_q[drv]   <= TGT_W'({trk_out, 5'd0});
							valid_q[drv] <= 1'b0;
							idx_q[drv]   <= '0;
						end
					end
					OP_SECTOR: begin
						tgt_q[drv]   <= TGT_W'({track_q[drv], sect_cur[4:0]});
						idx_q[drv]   <= '0;
						valid_q[drv] <= 1'b0;
						sect_q[drv]  <= sect_cur + SECT_W'(1);
					end
					OP_WRITE: begin
						if (idx_ok) idx_q[drv] <= idx_q[drv] + 8'd1;
						dirty_q[drv] <= 1'b1;
						cnt_q[drv]   <= cnt_next;
					end
					default: begin
					end
				endcase
			end

			// Finish a flush: rewind, clean, and end a full write burst
			if (cmd.flush && sts.copy_done) begin
				idx_q[drv]   <= '0;
				dirty_q[drv] <= 1'b0;
				if (op_q == OP_WRITE) begin
					cnt_q[drv]  <= '0;
					stat_q[drv] <= stat_q[drv] | ST_ENWD;
				end
			end

			// Finish a fill
			if (cmd.fill && sts.copy_done) begin
				idx_q[drv]   <= '0;
				valid_q[drv] <= 1'b1;
			end

			// Step the read pointer
			if (cmd.read) begin
				ok_q <= idx_ok;
				if (idx_ok) idx_q[drv] <= idx_q[drv] + 8'd1;
			end
		end
	end

	a_cp_range: assert property (@(posedge clk) disable iff (!arst_n)
		cp_q <= 8'(SECTOR_BYTES))
		else $error("copy counter ran past the sector length");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q[drv] <= 8'(SECTOR_BYTES))
		else $error("buffer pointer ran past the sector length");

	a_one_copy: assert property (@(posedge clk) disable iff (!arst_n)
		!(fill_we_s1 && flush_we_s1))
		else $error("fill and flush overlap");

endmodule

// ===== design/floppy_disk_controller_ports_unit.sv =====
// ----------------------------------------------------------------------------
// floppy_disk_controller_ports_unit
// Hard-sectored floppy controller behind I/O ports, with per-drive sector
// buffers and an on-chip disk image.
// ----------------------------------------------------------------------------
// Each port access returns one byte. Select, control, status, sector and
// data write accesses step through check, update and result, and a
// buffered data read adds a read step; an access that moves a sector between
// the drive's buffer and the disk image adds a flush or fill copy, one byte
// per cycle over the single write port of each memory. A new item can be
// taken in the cycle its predecessor's result is offered, if that result is
// taken in that cycle. After reset the disk image is cleared to zero one
// byte a cycle, DRIVES*TRACKS*32*137 bytes (140288 at the default size),
// before the first access is taken.
module floppy_disk_controller_ports_unit import fdc_pkg::*; #(
	parameter int DRIVES = FDC_DRIVES,
	parameter int TRACKS = FDC_TRACKS
) (
	input logic         clk,
	input logic         arst_n,
	fdc_req_if.sink     req,
	fdc_rsp_if.source   rsp
);

	fdc_cmd_t cmd;
	fdc_sts_t sts;

	fdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fdc_dp #(
		.DRIVES (DRIVES),
		.TRACKS (TRACKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (req.op),
		.in_data   (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.rd_data_q (rsp.read_data)
	);

endmodule
